// ----- rtl/ufwh_pkg.sv -----
// ----------------------------------------------------------------------------
// ufwh_pkg
// Shared types, constants and helpers for the weighted union-find engine.
// ----------------------------------------------------------------------------
package ufwh_pkg;

  // Fixed field widths of the item channels
  localparam int SITE_W  = 6;
  localparam int COUNT_W = 8;

  // Default store depth
  localparam int DEF_SITE_COUNT = 64;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Access-count bookkeeping
  localparam logic [COUNT_W-1:0] COUNT_INIT = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_STEP = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(255);

  typedef struct packed {
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
  } in_item_t;

  typedef struct packed {
    logic              already_connected;
    logic [SITE_W-1:0] merged_root;
    logic [COUNT_W-1:0] access_count;
  } out_item_t;

  // Add one step to the access count, holding at the maximum
  function automatic logic [COUNT_W-1:0] count_step(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W:0] sum;
    sum = {1'b0, cnt} + {1'b0, COUNT_STEP};
    if (sum > {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return sum[COUNT_W-1:0];
  endfunction

endpackage

// ----- rtl/ufwh_front.sv -----
// ----------------------------------------------------------------------------
// ufwh_front
// Input side: takes union requests, reduces site indexes into the store
// range and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module ufwh_front import ufwh_pkg::*; #(
  parameter int SITE_COUNT = DEF_SITE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  in_item_t                      in_item,
  input  logic                          clearing,
  output logic                          q_valid,
  output logic [$clog2(SITE_COUNT)-1:0] q_a,
  output logic [$clog2(SITE_COUNT)-1:0] q_b,
  input  logic                          q_pop
);

  localparam int NODE_W   = $clog2(SITE_COUNT);
  localparam int TBL_N    = 2 ** SITE_W;
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Constant table: site index modulo the store depth
  logic [NODE_W-1:0] mod_tbl [TBL_N];

  for (genvar i = 0; i < TBL_N; i++) begin : g_mod
    assign mod_tbl[i] = NODE_W'(i % SITE_COUNT);
  end

  logic [NODE_W-1:0] qa_mem [QUEUE_DEPTH];
  logic [NODE_W-1:0] qb_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              full;
  logic              push;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign in_stall = full || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_a      = qa_mem[rd_ptr_r];
  assign q_b      = qb_mem[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      qa_mem[wr_ptr_r] <= mod_tbl[in_item.site_a];
      qb_mem[wr_ptr_r] <= mod_tbl[in_item.site_b];
    end
  end

endmodule

// ----- rtl/ufwh_engine.sv -----
// ----------------------------------------------------------------------------
// ufwh_engine
// Back side: walks both sites to their roots with path halving, merges the
// trees by size and registers the result. Owns the parent and size stores.
// ----------------------------------------------------------------------------
module ufwh_engine import ufwh_pkg::*; #(
  parameter int SITE_COUNT = DEF_SITE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [$clog2(SITE_COUNT)-1:0] q_a,
  input  logic [$clog2(SITE_COUNT)-1:0] q_b,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output out_item_t                     out_item
);

  localparam int NODE_W = $clog2(SITE_COUNT);
  localparam int SIZE_W = $clog2(SITE_COUNT + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_HOP   = 3'd3;
  localparam logic [2:0] ST_MERGE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(SITE_COUNT - 1);

  // Stores
  logic [NODE_W-1:0] parent_mem [SITE_COUNT];
  logic [SIZE_W-1:0] size_mem   [SITE_COUNT];

  logic [2:0]         state_r, state_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [NODE_W-1:0]  b_r, b_nxt;
  logic [NODE_W-1:0]  ra_r, ra_nxt;
  logic               walk_b_r, walk_b_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [NODE_W-1:0]  root_r, root_nxt;
  logic               joined_r, joined_nxt;
  logic [NODE_W-1:0]  clr_r, clr_nxt;

  logic [NODE_W-1:0]  p_raddr;
  logic [NODE_W-1:0]  p_q;
  logic               pw_en;
  logic [NODE_W-1:0]  pw_addr;
  logic [NODE_W-1:0]  pw_data;
  logic [SIZE_W-1:0]  sz_a_q;
  logic [SIZE_W-1:0]  sz_b_q;
  logic               sw_en;
  logic [NODE_W-1:0]  sw_addr;
  logic [SIZE_W-1:0]  sw_data;
  logic               out_load;
  logic               out_valid_r;
  out_item_t          out_item_r;

  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    node_nxt   = node_r;
    b_nxt      = b_r;
    ra_nxt     = ra_r;
    walk_b_nxt = walk_b_r;
    cnt_nxt    = cnt_r;
    root_nxt   = root_r;
    joined_nxt = joined_r;
    clr_nxt    = clr_r;
    p_raddr    = node_r;
    pw_en      = 1'b0;
    pw_addr    = node_r;
    pw_data    = p_q;
    sw_en      = 1'b0;
    sw_addr    = ra_r;
    sw_data    = sz_a_q + sz_b_q;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        // identity links and unit sizes, one entry per cycle
        pw_en   = 1'b1;
        pw_addr = clr_r;
        pw_data = clr_r;
        sw_en   = 1'b1;
        sw_addr = clr_r;
        sw_data = SIZE_W'(1);
        if (clr_r == LAST_NODE) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          node_nxt   = q_a;
          b_nxt      = q_b;
          walk_b_nxt = 1'b0;
          cnt_nxt    = COUNT_INIT;
          p_raddr    = q_a;
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (p_q == node_r) begin
          // node is a root
          if (!walk_b_r) begin
            ra_nxt     = node_r;
            node_nxt   = b_r;
            walk_b_nxt = 1'b1;
            p_raddr    = b_r;
          end else if (ra_r == node_r) begin
            joined_nxt = 1'b1;
            root_nxt   = node_r;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_MERGE;
          end
        end else begin
          // fetch the grandparent
          p_raddr   = p_q;
          state_nxt = ST_HOP;
        end
      end
      ST_HOP: begin
        // relink to grandparent and continue from there
        pw_en     = 1'b1;
        pw_addr   = node_r;
        pw_data   = p_q;
        node_nxt  = p_q;
        cnt_nxt   = count_step(cnt_r);
        p_raddr   = p_q;
        state_nxt = ST_CHK;
      end
      ST_MERGE: begin
        // node_r holds the second root; smaller tree goes under the larger
        pw_en      = 1'b1;
        sw_en      = 1'b1;
        joined_nxt = 1'b0;
        cnt_nxt    = count_step(cnt_r);
        if (sz_a_q < sz_b_q) begin
          pw_addr  = ra_r;
          pw_data  = node_r;
          sw_addr  = node_r;
          root_nxt = node_r;
        end else begin
          pw_addr  = node_r;
          pw_data  = ra_r;
          sw_addr  = ra_r;
          root_nxt = ra_r;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      walk_b_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      walk_b_r <= walk_b_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    b_r      <= b_nxt;
    ra_r     <= ra_nxt;
    cnt_r    <= cnt_nxt;
    root_r   <= root_nxt;
    joined_r <= joined_nxt;
    if (out_load) begin
      out_item_r.already_connected <= joined_r;
      out_item_r.merged_root       <= SITE_W'(root_r);
      out_item_r.access_count      <= cnt_r;
    end
  end

  // Parent store: one write, one registered read
  always_ff @(posedge clk) begin
    if (pw_en) begin
      parent_mem[pw_addr] <= pw_data;
    end
    p_q <= parent_mem[p_raddr];
  end

  // Size store: one write, two registered reads at the two roots
  always_ff @(posedge clk) begin
    if (sw_en) begin
      size_mem[sw_addr] <= sw_data;
    end
    sz_a_q <= size_mem[ra_r];
    sz_b_q <= size_mem[node_r];
  end

endmodule

// ----- rtl/union_find_weighted_halving.sv -----
// Flow: a request is registered into the queue, then the engine walks both sites, then merges if needed.
// Throughput: one request at a time in the engine; each hop costs a read of the
// parent store (registered) plus the relink.
// Reset: a clearing pass loads identity links and unit sizes;
// in_stall stays high until it ends.
// ----------------------------------------------------------------------------
// union_find_weighted_halving
// Weighted quick-union engine with path halving: queue front, walk/merge back.
// ----------------------------------------------------------------------------
module union_find_weighted_halving import ufwh_pkg::*; #(
  parameter int SITE_COUNT = DEF_SITE_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int NODE_W = $clog2(SITE_COUNT);

  logic              q_valid;
  logic [NODE_W-1:0] q_a;
  logic [NODE_W-1:0] q_b;
  logic              q_pop;
  logic              clearing;

  // Request intake and queue
  ufwh_front #(
    .SITE_COUNT(SITE_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_a      (q_a),
    .q_b      (q_b),
    .q_pop    (q_pop)
  );

  // Walk, merge and result register
  ufwh_engine #(
    .SITE_COUNT(SITE_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_a       (q_a),
    .q_b       (q_b),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Engine only takes an item that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // No intake during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_stall)
    else $error("input accepted during clearing pass");

  // A merge always costs at least the base plus one merge step
  a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.already_connected) |->
      (out_item.access_count >= (COUNT_INIT + COUNT_STEP)))
    else $error("merge result with too small access count");

  // Engine does not pop while a clearing pass runs
  a_clear_pop: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

endmodule

// ----- dv/union_find_weighted_halving_tb.sv -----
// ----------------------------------------------------------------------------
// union_find_weighted_halving_tb
// Self-checking bench for the weighted union-find engine. A scoreboard model
// of the parent links and tree sizes predicts every union result, including
// path halving and the access count. Directed unions build deep trees and hit
// the merge-order rules, then random requests run under three idle patterns.
// ----------------------------------------------------------------------------
module union_find_weighted_halving_tb import ufwh_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SITE_COUNT  = DEF_SITE_COUNT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 48;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Scoreboard copy of the forest
  logic [SITE_W-1:0] link_model [SITE_COUNT];
  logic [6:0]        size_model [SITE_COUNT];

  out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 34;
  int        recv_idle_pct = 57;

  union_find_weighted_halving #(
    .SITE_COUNT(SITE_COUNT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void clear_forest();
    for (int k = 0; k < SITE_COUNT; k++) begin
      link_model[k] = SITE_W'(k);
      size_model[k] = 7'd1;
    end
  endfunction

  // Walk to the root, relinking each visited node to its grandparent
  function automatic logic [SITE_W-1:0] halving_walk(input logic [SITE_W-1:0] start,
                                                     inout int unsigned tally);
    logic [SITE_W-1:0] node;
    logic [SITE_W-1:0] up;
    int unsigned hops;
    node = start;
    hops = 0;
    while (link_model[node] != node && hops < SITE_COUNT) begin
      up = link_model[node];
      link_model[node] = link_model[up];
      node = link_model[node];
      tally += 5;
      hops++;
    end
    return node;
  endfunction

  // Apply one union request to the model and return its result
  function automatic out_item_t predict_union(input in_item_t req);
    out_item_t   res;
    logic [SITE_W-1:0] root_a;
    logic [SITE_W-1:0] root_b;
    int unsigned tally;
    // site indices are 6 bits wide, so they are always inside the store
    tally = 2;
    root_a = halving_walk(req.site_a, tally);
    root_b = halving_walk(req.site_b, tally);
    res = '0;
    if (root_a == root_b) begin
      res.already_connected = 1'b1;
      res.merged_root = root_a;
    end else begin
      if (size_model[root_a] < size_model[root_b]) begin
        link_model[root_a] = root_b;
        size_model[root_b] = size_model[root_b] + size_model[root_a];
        res.merged_root = root_b;
      end else begin
        link_model[root_b] = root_a;
        size_model[root_a] = size_model[root_a] + size_model[root_b];
        res.merged_root = root_a;
      end
      tally += 5;
    end
    if (tally > COUNT_MAX) tally = COUNT_MAX;
    res.access_count = COUNT_W'(tally);
    return res;
  endfunction

  // Root lookup for stimulus choice; leaves the model untouched
  function automatic logic [SITE_W-1:0] peek_root(input logic [SITE_W-1:0] site);
    logic [SITE_W-1:0] node;
    int hops;
    node = site;
    hops = 0;
    while (link_model[node] != node && hops < SITE_COUNT) begin
      node = link_model[node];
      hops++;
    end
    return node;
  endfunction

  // Result checker and receiver stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: conn=%0d root=%0d count=%0d",
                   out_item.already_connected, out_item.merged_root, out_item.access_count);
      end else begin
        want = pending_results.pop_front();
        if (out_item.already_connected !== want.already_connected ||
            out_item.merged_root !== want.merged_root ||
            out_item.access_count !== want.access_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch: want conn=%0d root=%0d count=%0d, ",
                      "got conn=%0d root=%0d count=%0d"},
                     want.already_connected, want.merged_root, want.access_count,
                     out_item.already_connected, out_item.merged_root, out_item.access_count);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Send one union request; returns at the edge where it is accepted
  task automatic send_request(input logic [SITE_W-1:0] a, input logic [SITE_W-1:0] b);
    in_item_t req;
    req.site_a = a;
    req.site_b = b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_union(req));
  endtask

  // Hold the sender off until every result is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Self unions at both ends of the site range
  task automatic test_self_union();
    send_request(6'd0, 6'd0);
    send_request(6'd63, 6'd63);
  endtask

  // Equal-size merges root to root: depth-3 tree 7 -> 6 -> 4 -> 0
  task automatic test_equal_merge_tree();
    send_request(6'd0, 6'd1);
    send_request(6'd2, 6'd3);
    send_request(6'd4, 6'd5);
    send_request(6'd6, 6'd7);
    send_request(6'd0, 6'd2);
    send_request(6'd4, 6'd6);
    send_request(6'd0, 6'd4);
  endtask

  // Long walks with halving from the deepest leaf
  task automatic test_deep_walk();
    send_request(6'd7, 6'd5);
    send_request(6'd7, 6'd7);
  endtask

  // Smaller tree goes under the larger one, with the smaller tree as the first site
  task automatic test_smaller_under_larger();
    send_request(6'd8, 6'd0);
    send_request(6'd62, 6'd61);
    send_request(6'd62, 6'd0);
    send_request(6'd63, 6'd0);
    send_request(6'd0, 6'd63);
  endtask

  // Random requests; merge_pct steers pairs toward different sets
  task automatic test_random_unions(input int count, input int merge_pct);
    logic [SITE_W-1:0] a;
    logic [SITE_W-1:0] b;
    int tries;
    for (int n = 0; n < count; n++) begin
      a = SITE_W'($urandom_range(0, SITE_COUNT - 1));
      b = SITE_W'($urandom_range(0, SITE_COUNT - 1));
      if ($urandom_range(0, 99) < 5) begin
        b = a;
      end else if ($urandom_range(0, 99) < merge_pct) begin
        tries = 0;
        while (peek_root(a) == peek_root(b) && tries < 8) begin
          b = SITE_W'($urandom_range(0, SITE_COUNT - 1));
          tries++;
        end
      end
      send_request(a, b);
    end
  endtask

  // Main sequence
  initial begin
    clear_forest();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 57;
    test_self_union();
    test_equal_merge_tree();
    test_deep_walk();
    test_smaller_under_larger();
    test_random_unions(620, 70);
    wait_for_drain();

    send_idle_pct = 57;
    recv_idle_pct = 34;
    test_random_unions(620, 30);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_unions(610, 30);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ufwh_pkg.sv
rtl/ufwh_front.sv
rtl/ufwh_engine.sv
rtl/union_find_weighted_halving.sv
dv/union_find_weighted_halving_tb.sv
